>>> rtl/afp_pkg.sv
`timescale 1ns / 1ps
// Audio frame pacer package: command and status codes, register indexes,
// configuration and result structs. No dependencies.
package afp_pkg;

  // Command codes carried in a request transaction
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_MIC_WRITE  = 3'd1,
    CMD_SPK_READ   = 3'd2,
    CMD_MIC_ENABLE = 3'd3,
    CMD_SPK_ENABLE = 3'd4
  } cmd_e;

  // Tick status codes reported in a result transaction
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_FRAME     = 3'd1,
    ST_MIC_SHORT = 3'd2,
    ST_SPK_SHORT = 3'd3,
    ST_NO_DEVICE = 3'd4
  } status_e;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP_THRESH = 2'd2;

  localparam logic [15:0] FRAME_INTERVAL_RST = 16'd80;
  localparam logic [15:0] STALE_LIMIT_RST    = 16'd300;
  localparam logic [15:0] CATCHUP_THRESH_RST = 16'd16;

  typedef struct packed {
    logic [15:0] frame_interval;
    logic [15:0] stale_limit;
    logic [15:0] catchup_thresh;
  } cfg_t;

  typedef struct packed {
    logic        frame_elapsed;
    logic [2:0]  tick_status;
    logic        resynced;
    logic        catch_up;
    logic        clock_running;
  } res_t;

endpackage

>>> rtl/afp_cfg.sv
`timescale 1ns / 1ps
// Audio frame pacer configuration registers with a plain write port.
// Depends on afp_pkg.
module afp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output afp_pkg::cfg_t                  cfg
);
  import afp_pkg::*;

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_interval <= FRAME_INTERVAL_RST;
      cfg.stale_limit    <= STALE_LIMIT_RST;
      cfg.catchup_thresh <= CATCHUP_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_INTERVAL: cfg.frame_interval <= cfg_wdata;
        CFG_STALE_LIMIT:    cfg.stale_limit    <= cfg_wdata;
        CFG_CATCHUP_THRESH: cfg.catchup_thresh <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/afp_engine.sv
`timescale 1ns / 1ps
// Audio frame pacer state registers and the single-pass update logic that
// turns one command into a result. Depends on afp_pkg.
module afp_engine #(
  parameter int TIME_WIDTH     = 40,
  parameter int CONSUMED_WIDTH = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [2:0]     cmd,
  input  logic [39:0]    now_ms,
  input  logic [15:0]    duration_ms,
  input  logic           enable,
  input  afp_pkg::cfg_t  cfg,
  output afp_pkg::res_t  res
);
  import afp_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int CW = CONSUMED_WIDTH;

  logic [TW-1:0] deadline, deadline_next;
  logic [CW-1:0] mic_cnt, mic_cnt_next;
  logic [CW-1:0] spk_cnt, spk_cnt_next;
  logic          mic_on, mic_on_next;
  logic          spk_on, spk_on_next;
  logic          running, running_next;
  logic          mic_pend, mic_pend_next;
  logic          spk_pend, spk_pend_next;

  logic [TW-1:0] now_t, ivl_t, now_plus, late, d1, d_adv;
  logic          stale, due;
  logic [CW-1:0] ivl_c, mic1, spk1, mic_left, spk_left, mic_sat, spk_sat;
  logic          mic_ok, spk_ok, cu;
  logic [CW:0]   mic_sum, spk_sum;
  logic          mic_on_new, spk_on_new;

  // Datapath terms shared by the command arms
  always_comb begin
    now_t    = TW'(now_ms);
    ivl_t    = TW'(cfg.frame_interval);
    now_plus = now_t + ivl_t;
    late     = now_t - deadline;
    stale    = (deadline == '0) ||
               ((now_t > deadline) && (late > TW'(cfg.stale_limit)));
    // deadline and counts as seen after a possible stale resync
    d1       = stale ? now_plus : deadline;
    mic1     = stale ? '0 : mic_cnt;
    spk1     = stale ? '0 : spk_cnt;
    due      = now_t >= d1;
    d_adv    = d1 + ivl_t;
    ivl_c    = CW'(cfg.frame_interval);
    mic_ok   = mic1 >= ivl_c;
    spk_ok   = spk1 >= ivl_c;
    mic_left = mic1 - ivl_c;
    spk_left = spk1 - ivl_c;
    cu       = mic_left > CW'(cfg.catchup_thresh);
    // saturating adds for write and read events
    mic_sum  = {1'b0, mic_cnt} + (CW+1)'(duration_ms);
    spk_sum  = {1'b0, spk_cnt} + (CW+1)'(duration_ms);
    mic_sat  = mic_sum[CW] ? '1 : mic_sum[CW-1:0];
    spk_sat  = spk_sum[CW] ? '1 : spk_sum[CW-1:0];
    mic_on_new = (cmd == CMD_MIC_ENABLE) ? enable : mic_on;
    spk_on_new = (cmd == CMD_SPK_ENABLE) ? enable : spk_on;
  end

  // Next state and result for the command in the input register
  always_comb begin
    deadline_next = deadline;
    mic_cnt_next  = mic_cnt;
    spk_cnt_next  = spk_cnt;
    mic_on_next   = mic_on;
    spk_on_next   = spk_on;
    running_next  = running;
    mic_pend_next = mic_pend;
    spk_pend_next = spk_pend;
    res           = '0;
    case (cmd)
      CMD_TICK: begin
        if (running) begin
          if (stale) begin
            deadline_next = now_plus;
            mic_cnt_next  = '0;
            spk_cnt_next  = '0;
            res.resynced  = 1'b1;
          end
          if (due) begin
            if (mic_on) begin
              if (mic_ok) begin
                deadline_next     = cu ? (d_adv - TW'(1)) : d_adv;
                mic_cnt_next      = mic_left;
                res.frame_elapsed = 1'b1;
                res.tick_status   = ST_FRAME;
                res.catch_up      = cu;
              end else begin
                res.tick_status = ST_MIC_SHORT;
              end
            end else if (spk_on) begin
              if (spk_ok) begin
                deadline_next     = d_adv;
                spk_cnt_next      = spk_left;
                res.frame_elapsed = 1'b1;
                res.tick_status   = ST_FRAME;
              end else begin
                res.tick_status = ST_SPK_SHORT;
              end
            end else begin
              res.tick_status = ST_NO_DEVICE;
            end
          end
        end
      end
      CMD_MIC_WRITE: begin
        mic_cnt_next = mic_sat;
        // first write after enable realigns the deadline
        if (mic_pend) begin
          mic_pend_next = 1'b0;
          deadline_next = now_plus;
          mic_cnt_next  = '0;
          res.resynced  = 1'b1;
        end
      end
      CMD_SPK_READ: begin
        spk_cnt_next = spk_sat;
        if (spk_pend) begin
          spk_pend_next = 1'b0;
          deadline_next = now_plus;
          spk_cnt_next  = ivl_c;
          res.resynced  = 1'b1;
        end
      end
      CMD_MIC_ENABLE, CMD_SPK_ENABLE: begin
        mic_on_next  = mic_on_new;
        spk_on_next  = spk_on_new;
        mic_cnt_next = '0;
        spk_cnt_next = '0;
        if (!mic_on_new && !spk_on_new) begin
          running_next = 1'b0;
        end else begin
          deadline_next = now_plus;
          res.resynced  = 1'b1;
          if (mic_on_new ^ spk_on_new) running_next = 1'b1;
        end
        if (enable) begin
          if (cmd == CMD_MIC_ENABLE) mic_pend_next = 1'b1;
          else                       spk_pend_next = 1'b1;
        end
      end
      default: ;
    endcase
    res.clock_running = running_next;
  end

  // State registers advance as the transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline <= '0;
      mic_cnt  <= '0;
      spk_cnt  <= '0;
      mic_on   <= 1'b0;
      spk_on   <= 1'b0;
      running  <= 1'b0;
      mic_pend <= 1'b0;
      spk_pend <= 1'b0;
    end else if (fire) begin
      deadline <= deadline_next;
      mic_cnt  <= mic_cnt_next;
      spk_cnt  <= spk_cnt_next;
      mic_on   <= mic_on_next;
      spk_on   <= spk_on_next;
      running  <= running_next;
      mic_pend <= mic_pend_next;
      spk_pend <= spk_pend_next;
    end
  end

endmodule

>>> rtl/audio_frame_pacer_core.sv
`timescale 1ns / 1ps
// Audio frame pacer top level: input register, pacing engine, result register.
// Depends on afp_pkg, afp_cfg and afp_engine.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  request  | in_valid / in_ready | cmd, now_ms, duration_ms, enable
//  result   | out_valid/out_ready | frame_elapsed, tick_status, resynced,
//           |                     | catch_up, clock_running
//  config   | cfg_we              | cfg_index, cfg_wdata
//
// One result per request, through the input register and then the result register;
// one request per cycle sustained while results are taken (single-pass engine).
// Synchronous active-high reset clears all pacing state and loads register defaults.
// A stalled result holds the input register; the input register takes a new
// request whenever it is empty or moving forward in the same cycle.
module audio_frame_pacer_core #(
  parameter int TIME_WIDTH     = 40,
  parameter int CONSUMED_WIDTH = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic [39:0]                    now_ms,
  input  logic [15:0]                    duration_ms,
  input  logic                           enable,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           frame_elapsed,
  output logic [2:0]                     tick_status,
  output logic                           resynced,
  output logic                           catch_up,
  output logic                           clock_running,
  input  logic                           cfg_we,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import afp_pkg::*;

  cfg_t        cfg;
  res_t        res_c, res_q;
  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [39:0] s1_now;
  logic [15:0] s1_dur;
  logic        s1_en;
  logic        fire;

  afp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake: input stage moves forward when the result slot is free
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd <= cmd;
      s1_now <= now_ms;
      s1_dur <= duration_ms;
      s1_en  <= enable;
    end
  end

  afp_engine #(
    .TIME_WIDTH     (TIME_WIDTH),
    .CONSUMED_WIDTH (CONSUMED_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cmd         (s1_cmd),
    .now_ms      (s1_now),
    .duration_ms (s1_dur),
    .enable      (s1_en),
    .cfg         (cfg),
    .res         (res_c)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_q <= res_c;
  end

  assign frame_elapsed = res_q.frame_elapsed;
  assign tick_status   = res_q.tick_status;
  assign resynced      = res_q.resynced;
  assign catch_up      = res_q.catch_up;
  assign clock_running = res_q.clock_running;

`ifndef SYNTH
  // frame flag and frame status always agree
  a_frame_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_elapsed == (tick_status == ST_FRAME)))
    else $error("frame flag and status disagree");

  // catch-up only happens on an emitted frame
  a_catchup_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && catch_up) |-> frame_elapsed)
    else $error("catch-up without frame");

  // a tick reports a status only while the pacing clock runs
  a_status_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (tick_status != ST_IDLE)) |-> clock_running)
    else $error("tick status while clock stopped");

  // full input stage behind a stalled result must back-pressure
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while pipeline is full");

  // an accepted request occupies the input stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted request lost");
`endif

endmodule
